### hdl/adsr_pkg.sv
// Package for the ADSR envelope amplitude unit: item types, widths, register
// indexes and the payload records that travel along the divider chains.
// No dependencies.
package adsr_pkg;

  localparam int unsigned TICK_W  = 32;
  localparam int unsigned LVL_W   = 16;
  localparam int unsigned REM_W   = TICK_W + LVL_W;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CIDX_W  = 3;

  localparam logic [LVL_W-1:0] FLOOR_LEVEL = 16'd327;

  localparam logic [CIDX_W-1:0] REG_ATTACK  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_DECAY   = 3'd1;
  localparam logic [CIDX_W-1:0] REG_RELEASE = 3'd2;
  localparam logic [CIDX_W-1:0] REG_PEAK    = 3'd3;
  localparam logic [CIDX_W-1:0] REG_SUSTAIN = 3'd4;

  typedef struct packed {
    logic [TICK_W-1:0] now_tick;
    logic [TICK_W-1:0] start_tick;
    logic [TICK_W-1:0] stop_tick;
  } in_item_t;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic             done_res;
  } out_item_t;

  // Carried alongside the held-curve division.
  typedef struct packed {
    logic [LVL_W-1:0]  base;
    logic              neg;
    logic              zero;
    logic              sus;
    logic              rel;
    logic [TICK_W-1:0] t;
    logic              done;
  } held_pl_t;

  // Carried alongside the release division.
  typedef struct packed {
    logic [LVL_W-1:0] lvl_h;
    logic             rel;
    logic             rz;
    logic             done;
  } rel_pl_t;

endpackage

### hdl/adsr_div_cell.sv
// One restoring-division cell: settles a single quotient bit and passes the
// partial remainder, divisor and side payload on. Depends on adsr_pkg.
module adsr_div_cell #(
  parameter int unsigned BIT = 0,
  parameter int unsigned PW  = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          v_i,
  input  logic [adsr_pkg::REM_W-1:0]    rem_i,
  input  logic [adsr_pkg::TICK_W-1:0]   div_i,
  input  logic [adsr_pkg::LVL_W-1:0]    q_i,
  input  logic [PW-1:0]                 pl_i,
  output logic                          v_o,
  output logic [adsr_pkg::REM_W-1:0]    rem_o,
  output logic [adsr_pkg::TICK_W-1:0]   div_o,
  output logic [adsr_pkg::LVL_W-1:0]    q_o,
  output logic [PW-1:0]                 pl_o
);
  import adsr_pkg::*;

  logic [REM_W-1:0] dsh;
  logic             ge;
  logic [REM_W-1:0] rem_d;
  logic [LVL_W-1:0] q_d;
  logic             v_q;
  logic [REM_W-1:0] rem_q;
  logic [TICK_W-1:0] div_q;
  logic [LVL_W-1:0] q_q;
  logic [PW-1:0]    pl_q;

  always_comb begin
    dsh      = {{LVL_W{1'b0}}, div_i} << BIT;
    ge       = (rem_i >= dsh);
    rem_d    = ge ? (rem_i - dsh) : rem_i;
    q_d      = q_i;
    q_d[BIT] = ge;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_i;
    q_q   <= q_d;
    pl_q  <= pl_i;
  end

  assign v_o   = v_q;
  assign rem_o = rem_q;
  assign div_o = div_q;
  assign q_o   = q_q;
  assign pl_o  = pl_q;

endmodule

### hdl/adsr_div_chain.sv
// Row of division cells giving a 16-bit quotient, one bit per cell and one
// item per cycle. Depends on adsr_pkg and adsr_div_cell.
module adsr_div_chain #(
  parameter int unsigned PW = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          v_i,
  input  logic [adsr_pkg::REM_W-1:0]    num_i,
  input  logic [adsr_pkg::TICK_W-1:0]   div_i,
  input  logic [PW-1:0]                 pl_i,
  output logic                          v_o,
  output logic [adsr_pkg::LVL_W-1:0]    q_o,
  output logic [PW-1:0]                 pl_o
);
  import adsr_pkg::*;

  logic              v   [LVL_W+1];
  logic [REM_W-1:0]  rem [LVL_W+1];
  logic [TICK_W-1:0] dv  [LVL_W+1];
  logic [LVL_W-1:0]  q   [LVL_W+1];
  logic [PW-1:0]     pl  [LVL_W+1];

  assign v[0]   = v_i;
  assign rem[0] = num_i;
  assign dv[0]  = div_i;
  assign q[0]   = '0;
  assign pl[0]  = pl_i;

  for (genvar i = 0; i < LVL_W; i++) begin : g_cell
    adsr_div_cell #(
      .BIT(LVL_W - 1 - i),
      .PW (PW)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .v_i   (v[i]),
      .rem_i (rem[i]),
      .div_i (dv[i]),
      .q_i   (q[i]),
      .pl_i  (pl[i]),
      .v_o   (v[i+1]),
      .rem_o (rem[i+1]),
      .div_o (dv[i+1]),
      .q_o   (q[i+1]),
      .pl_o  (pl[i+1])
    );
  end

  assign v_o  = v[LVL_W];
  assign q_o  = q[LVL_W];
  assign pl_o = pl[LVL_W];

endmodule

### hdl/adsr_envelope_amplitude_unit.sv
// ADSR envelope amplitude unit. Each item carries the current, note-on and
// note-off times; the unit returns the Q1.15 envelope level and a flag that
// marks a released note whose release has fully run out.
//
// Usage: raise start with the times on item_i; busy stays low, so an item
// is taken at every edge on which start is high. The result sits on res_o
// for one cycle with valid_o high, and results leave in the order the items
// arrived. Throughput is one item per cycle: the two divisions run through
// two rows of sixteen cells, one quotient bit per cell, and every stage in
// between is registered.
// The receiver cannot stall; results must be captured on the strobe.
// Configuration is to be written through cfg_we_i/cfg_idx_i/cfg_data_i
// only while no item is in flight; the unit does not enforce this. Reset
// empties the pipeline and loads the default attack, decay, release, peak
// and sustain settings. Depends on adsr_pkg, adsr_div_chain and adsr_div_cell.
module adsr_envelope_amplitude_unit #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  adsr_pkg::in_item_t            item_i,
  output logic                          valid_o,
  output adsr_pkg::out_item_t           res_o,
  input  logic                          cfg_we_i,
  input  logic [adsr_pkg::CIDX_W-1:0]   cfg_idx_i,
  input  logic [adsr_pkg::CFG_W-1:0]    cfg_data_i
);
  import adsr_pkg::*;

  localparam int unsigned LAT = 2 * LVL_W + 6;
  localparam logic [TICK_W-1:0] TMASK = (TIME_BITS >= TICK_W) ? {TICK_W{1'b1}} :
      TICK_W'((64'd1 << TIME_BITS) - 64'd1);

  logic [TICK_W-1:0] att_q, dec_q, rls_q;
  logic [LVL_W-1:0]  peak_q, sus_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      att_q  <= 32'd441;
      dec_q  <= 32'd4410;
      rls_q  <= 32'd4410;
      peak_q <= 16'd32768;
      sus_q  <= 16'd26214;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ATTACK:  att_q  <= cfg_data_i;
        REG_DECAY:   dec_q  <= cfg_data_i;
        REG_RELEASE: rls_q  <= cfg_data_i;
        REG_PEAK:    peak_q <= cfg_data_i[LVL_W-1:0];
        REG_SUSTAIN: sus_q  <= cfg_data_i[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Stage A: time differences and note phase.
  logic [TICK_W-1:0] now_w, sta_w, stp_w;
  logic              held_d, rel_d, done_d;
  logic [TICK_W-1:0] age_d, t_d;
  logic              va_q, rel_a_q, done_a_q;
  logic [TICK_W-1:0] age_a_q, t_a_q;

  always_comb begin
    now_w  = item_i.now_tick & TMASK;
    sta_w  = item_i.start_tick & TMASK;
    stp_w  = item_i.stop_tick & TMASK;
    held_d = (sta_w <= now_w) && ((now_w < stp_w) || (stp_w < sta_w));
    rel_d  = (sta_w <= now_w) && !held_d;
    age_d  = held_d ? (now_w - sta_w) : (stp_w - sta_w);
    t_d    = now_w - stp_w;
    done_d = (stp_w >= sta_w) &&
             ({1'b0, now_w} > ({1'b0, stp_w} + {1'b0, rls_q}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= start;
    end
  end

  // Items before note-on take the released path with a zero result.
  always_ff @(posedge clk_i) begin
    rel_a_q  <= !held_d;
    age_a_q  <= rel_d || held_d ? age_d : '0;
    t_a_q    <= rel_d ? t_d : rls_q;
    done_a_q <= done_d;
  end

  // Stage B: choose the curve segment and the multiply operands.
  logic              is_att, is_dec;
  logic              vb_q;
  logic [TICK_W-1:0] mul_a_q, div_b_q;
  logic [LVL_W-1:0]  mul_b_q;
  held_pl_t          pl_b_q;

  always_comb begin
    is_att = (age_a_q <= att_q);
    is_dec = !is_att && ({1'b0, age_a_q} <= ({1'b0, att_q} + {1'b0, dec_q}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_a_q     <= is_att ? age_a_q : (age_a_q - att_q);
    mul_b_q     <= is_att ? peak_q : ((sus_q >= peak_q) ? (sus_q - peak_q)
                                                         : (peak_q - sus_q));
    div_b_q     <= is_att ? att_q : dec_q;
    pl_b_q.base <= is_att ? '0 : peak_q;
    pl_b_q.neg  <= is_dec && (sus_q < peak_q);
    pl_b_q.zero <= is_att && (att_q == '0);
    pl_b_q.sus  <= !is_att && !is_dec;
    pl_b_q.rel  <= rel_a_q;
    pl_b_q.t    <= t_a_q;
    pl_b_q.done <= done_a_q;
  end

  // Stage C: product for the held curve.
  logic              vc_q;
  logic [REM_W-1:0]  prod_c_q;
  logic [TICK_W-1:0] div_c_q;
  held_pl_t          pl_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_c_q <= REM_W'(mul_a_q * mul_b_q);
    div_c_q  <= div_b_q;
    pl_c_q   <= pl_b_q;
  end

  logic             v1;
  logic [LVL_W-1:0] q1;
  held_pl_t         pl1;

  adsr_div_chain #(.PW($bits(held_pl_t))) u_held_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .v_i   (vc_q),
    .num_i (prod_c_q),
    .div_i (div_c_q),
    .pl_i  (pl_c_q),
    .v_o   (v1),
    .q_o   (q1),
    .pl_o  (pl1)
  );

  // Stage D: held level and release operands.
  logic             vd_q;
  logic [LVL_W-1:0] lvl_h_d;
  logic [TICK_W-1:0] rt_d_q;
  rel_pl_t          pl_d_q;

  always_comb begin
    if (pl1.zero) begin
      lvl_h_d = '0;
    end else if (pl1.sus) begin
      lvl_h_d = sus_q;
    end else if (pl1.neg) begin
      lvl_h_d = pl1.base - q1;
    end else begin
      lvl_h_d = pl1.base + q1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else begin
      vd_q <= v1;
    end
  end

  always_ff @(posedge clk_i) begin
    pl_d_q.lvl_h <= lvl_h_d;
    pl_d_q.rel   <= pl1.rel;
    pl_d_q.rz    <= !((rls_q != '0) && (pl1.t < rls_q));
    pl_d_q.done  <= pl1.done;
    rt_d_q       <= rls_q - pl1.t;
  end

  // Stage E: product for the release ramp.
  logic             ve_q;
  logic [REM_W-1:0] prod_e_q;
  rel_pl_t          pl_e_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
    end else begin
      ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_e_q <= REM_W'(pl_d_q.lvl_h * rt_d_q);
    pl_e_q   <= pl_d_q;
  end

  logic             v2;
  logic [LVL_W-1:0] q2;
  rel_pl_t          pl2;

  adsr_div_chain #(.PW($bits(rel_pl_t))) u_rel_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .v_i   (ve_q),
    .num_i (prod_e_q),
    .div_i (rls_q),
    .pl_i  (pl_e_q),
    .v_o   (v2),
    .q_o   (q2),
    .pl_o  (pl2)
  );

  // Stage F: pick the level, apply the noise floor and register the result.
  logic      [LVL_W-1:0] lvl_f;
  logic                  vf_q;
  out_item_t             res_q;

  always_comb begin
    if (!pl2.rel) begin
      lvl_f = pl2.lvl_h;
    end else if (pl2.rz) begin
      lvl_f = '0;
    end else begin
      lvl_f = q2;
    end
    if (lvl_f <= FLOOR_LEVEL) begin
      lvl_f = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else begin
      vf_q <= v2;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.level    <= lvl_f;
    res_q.done_res <= pl2.done;
  end

  assign valid_o = vf_q;
  assign res_o   = res_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start, LAT))
    else $error("result strobe without an item taken at the expected latency");

  a_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (res_o.level != '0)) |-> (res_o.level > FLOOR_LEVEL))
    else $error("level at or below the noise floor was not cleared");

  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && res_o.done_res) |-> (res_o.level == '0))
    else $error("finished note produced a non-zero level");

endmodule
